@@ design/tty_line_discipline_buffers_defines.svh @@
// Assertion macros shared by the terminal line discipline RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TTY_LINE_DISCIPLINE_BUFFERS_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_BUFFERS_DEFINES_SVH

// Check a property at every clock edge outside reset
`define TLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included
`define TLD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tld_pkg.sv @@
// Shared constants, codes and types of the terminal line discipline buffers.
// No dependencies; used by tld_ctrl, tld_datapath and the top level.
package tld_pkg;

    // Buffer sizes and console count
    localparam int RING_DEPTH    = 256;
    localparam int ECHO_DEPTH    = 256;
    localparam int CONSOLE_COUNT = 12;

    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int ECHO_AW    = $clog2(ECHO_DEPTH);
    localparam int ECHO_CW    = $clog2(ECHO_DEPTH + 1);
    localparam int CNT_XW     = RING_AW + 8;
    localparam int FKEY_LIMIT = (CONSOLE_COUNT < 12) ? CONSOLE_COUNT : 12;

    // Character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // Opcodes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // Special key kinds
    localparam logic [2:0] KIND_ENTER     = 3'd1;
    localparam logic [2:0] KIND_BACKSPACE = 3'd2;
    localparam logic [2:0] KIND_UP        = 3'd3;
    localparam logic [2:0] KIND_DOWN      = 3'd4;
    localparam logic [2:0] KIND_FKEY      = 3'd5;

    // Action codes
    localparam logic [1:0] ACT_NONE        = 2'd0;
    localparam logic [1:0] ACT_SCROLL_DOWN = 2'd1;
    localparam logic [1:0] ACT_SCROLL_UP   = 2'd2;
    localparam logic [1:0] ACT_CONSOLE     = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] key_char;
        logic       is_special;
        logic [2:0] special_kind;
        logic [3:0] fkey_index;
        logic       shift_held;
        logic       alt_held;
    } item_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] read_char;
        logic [1:0] action;
        logic [3:0] console_index;
        logic [7:0] cooked_count;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic xfer;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_enter;
        logic xfer_done;
    } status_t;

endpackage

@@ design/tld_datapath.sv @@
// Datapath: item register, edit/cooked/echo ring memories, pointers and result register.
// Depends on tld_pkg and tty_line_discipline_buffers_defines.svh.
`include "tty_line_discipline_buffers_defines.svh"

module tld_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  tld_pkg::item_t   s_item,
    input  tld_pkg::cmd_t    cmd,
    output tld_pkg::status_t st,
    output tld_pkg::result_t result
);

    localparam int RAW = tld_pkg::RING_AW;
    localparam int EAW = tld_pkg::ECHO_AW;
    localparam int ECW = tld_pkg::ECHO_CW;

    function automatic logic [RAW-1:0] ring_inc(input logic [RAW-1:0] p);
        return (p == RAW'(tld_pkg::RING_DEPTH - 1)) ? '0 : p + RAW'(1);
    endfunction

    function automatic logic [RAW-1:0] ring_dec(input logic [RAW-1:0] p);
        return (p == '0) ? RAW'(tld_pkg::RING_DEPTH - 1) : p - RAW'(1);
    endfunction

    function automatic logic [RAW-1:0] ring_fill(input logic [RAW-1:0] h,
                                                 input logic [RAW-1:0] t);
        logic [RAW:0] sum;
        begin
            sum = {1'b0, h} + (RAW+1)'(tld_pkg::RING_DEPTH) - {1'b0, t};
            if (h >= t)
            begin
                sum = {1'b0, h} - {1'b0, t};
            end
            return sum[RAW-1:0];
        end
    endfunction

    function automatic logic [EAW-1:0] echo_inc(input logic [EAW-1:0] p);
        return (p == EAW'(tld_pkg::ECHO_DEPTH - 1)) ? '0 : p + EAW'(1);
    endfunction

    tld_pkg::item_t   item_reg;
    tld_pkg::result_t res_reg;

    logic [7:0]     edit_mem   [tld_pkg::RING_DEPTH];
    logic [7:0]     cooked_mem [tld_pkg::RING_DEPTH];
    logic [7:0]     echo_mem   [tld_pkg::ECHO_DEPTH];

    logic [RAW-1:0] edit_head_reg, edit_tail_reg;
    logic [RAW-1:0] cooked_head_reg, cooked_tail_reg;
    logic [EAW-1:0] echo_head_reg, echo_tail_reg;
    logic [ECW-1:0] echo_count_reg;
    logic           pend_reg;
    logic           rd_hit_reg, echo_hit_reg;
    logic [7:0]     edit_rd_reg, cooked_rd_reg, echo_rd_reg;

    logic [RAW-1:0] edit_fill, cooked_fill;
    logic           op_key, ch_plain, ch_enter, ch_bs;
    logic           echo_push_en, edit_push_en, edit_drop_en, xfer_rd_en;
    logic           cooked_push_en, cooked_pop_en, echo_pop_en;
    logic [7:0]     echo_wchar, edit_wchar;
    logic [1:0]     action;
    logic [3:0]     console_index;
    logic [tld_pkg::CNT_XW-1:0] fill_ext;
    logic [7:0]     cooked_count;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= s_item;
        end
    end

    // Decode the item and qualify each ring operation
    always_comb
    begin
        edit_fill   = ring_fill(edit_head_reg, edit_tail_reg);
        cooked_fill = ring_fill(cooked_head_reg, cooked_tail_reg);

        op_key   = (item_reg.opcode == tld_pkg::OP_KEY);
        ch_plain = op_key && !item_reg.is_special;
        ch_enter = op_key && item_reg.is_special
                   && (item_reg.special_kind == tld_pkg::KIND_ENTER);
        ch_bs    = op_key && item_reg.is_special
                   && (item_reg.special_kind == tld_pkg::KIND_BACKSPACE);

        echo_wchar = ch_plain ? item_reg.key_char
                   : (ch_enter ? tld_pkg::CH_NEWLINE : tld_pkg::CH_BACKSPACE);
        edit_wchar = ch_plain ? item_reg.key_char : tld_pkg::CH_NEWLINE;

        echo_push_en   = cmd.exec && (ch_plain || ch_enter || ch_bs)
                         && (echo_count_reg != ECW'(tld_pkg::ECHO_DEPTH));
        edit_push_en   = cmd.exec && (ch_plain || ch_enter)
                         && (edit_fill < RAW'(tld_pkg::RING_DEPTH - 1));
        edit_drop_en   = cmd.exec && ch_bs && (edit_fill != '0);
        xfer_rd_en     = cmd.xfer && (edit_fill != '0);
        cooked_push_en = pend_reg && (cooked_fill < RAW'(tld_pkg::RING_DEPTH - 1));
        cooked_pop_en  = cmd.exec && (item_reg.opcode == tld_pkg::OP_READ)
                         && (cooked_fill != '0);
        echo_pop_en    = cmd.exec && (item_reg.opcode == tld_pkg::OP_DRAIN)
                         && (echo_count_reg != '0);
    end

    // Decode scroll and console selection
    always_comb
    begin
        action        = tld_pkg::ACT_NONE;
        console_index = 4'd0;
        if (op_key && item_reg.is_special)
        begin
            unique case (item_reg.special_kind)
                tld_pkg::KIND_UP:
                begin
                    if (item_reg.shift_held)
                    begin
                        action = tld_pkg::ACT_SCROLL_DOWN;
                    end
                end
                tld_pkg::KIND_DOWN:
                begin
                    if (item_reg.shift_held)
                    begin
                        action = tld_pkg::ACT_SCROLL_UP;
                    end
                end
                tld_pkg::KIND_FKEY:
                begin
                    if (item_reg.alt_held
                        && (item_reg.fkey_index < 4'(tld_pkg::FKEY_LIMIT)))
                    begin
                        action        = tld_pkg::ACT_CONSOLE;
                        console_index = item_reg.fkey_index;
                    end
                end
                default:
                begin
                    action = tld_pkg::ACT_NONE;
                end
            endcase
        end
    end

    // Saturate the cooked fill to the 8-bit count
    always_comb
    begin
        fill_ext     = tld_pkg::CNT_XW'(cooked_fill);
        cooked_count = (fill_ext > tld_pkg::CNT_XW'(255)) ? 8'hFF : fill_ext[7:0];
    end

    // Advance ring pointers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_head_reg   <= '0;
            edit_tail_reg   <= '0;
            cooked_head_reg <= '0;
            cooked_tail_reg <= '0;
            echo_head_reg   <= '0;
            echo_tail_reg   <= '0;
            echo_count_reg  <= '0;
            pend_reg        <= 1'b0;
            rd_hit_reg      <= 1'b0;
            echo_hit_reg    <= 1'b0;
        end
        else
        begin
            if (edit_push_en)
            begin
                edit_head_reg <= ring_inc(edit_head_reg);
            end
            else if (edit_drop_en)
            begin
                edit_head_reg <= ring_dec(edit_head_reg);
            end
            if (xfer_rd_en)
            begin
                edit_tail_reg <= ring_inc(edit_tail_reg);
            end
            if (cooked_push_en)
            begin
                cooked_head_reg <= ring_inc(cooked_head_reg);
            end
            if (cooked_pop_en)
            begin
                cooked_tail_reg <= ring_inc(cooked_tail_reg);
            end
            if (echo_push_en)
            begin
                echo_head_reg  <= echo_inc(echo_head_reg);
                echo_count_reg <= echo_count_reg + ECW'(1);
            end
            else if (echo_pop_en)
            begin
                echo_tail_reg  <= echo_inc(echo_tail_reg);
                echo_count_reg <= echo_count_reg - ECW'(1);
            end
            pend_reg <= xfer_rd_en;
            if (cmd.exec)
            begin
                rd_hit_reg   <= cooked_pop_en;
                echo_hit_reg <= echo_pop_en;
            end
        end
    end

    // Edit ring memory: push on key, read one entry per transfer beat
    always_ff @(posedge clk)
    begin
        if (edit_push_en)
        begin
            edit_mem[edit_head_reg] <= edit_wchar;
        end
        if (xfer_rd_en)
        begin
            edit_rd_reg <= edit_mem[edit_tail_reg];
        end
    end

    // Cooked ring memory: fill from the transfer, pop on read
    always_ff @(posedge clk)
    begin
        if (cooked_push_en)
        begin
            cooked_mem[cooked_head_reg] <= edit_rd_reg;
        end
        if (cooked_pop_en)
        begin
            cooked_rd_reg <= cooked_mem[cooked_tail_reg];
        end
    end

    // Echo queue memory: push echoed characters, pop on drain
    always_ff @(posedge clk)
    begin
        if (echo_push_en)
        begin
            echo_mem[echo_head_reg] <= echo_wchar;
        end
        if (echo_pop_en)
        begin
            echo_rd_reg <= echo_mem[echo_tail_reg];
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_reg.echo_valid    <= echo_hit_reg;
            res_reg.echo_char     <= echo_hit_reg ? echo_rd_reg : tld_pkg::CH_NUL;
            res_reg.read_char     <= rd_hit_reg ? cooked_rd_reg : tld_pkg::CH_NUL;
            res_reg.action        <= action;
            res_reg.console_index <= console_index;
            res_reg.cooked_count  <= cooked_count;
        end
    end

    assign result       = res_reg;
    assign st.is_enter  = ch_enter;
    assign st.xfer_done = (edit_fill == '0) && !pend_reg;

    `TLD_ASSERT(a_echo_count_match,
        (echo_head_reg == echo_tail_reg) |->
            (echo_count_reg == '0 || echo_count_reg == ECW'(tld_pkg::ECHO_DEPTH)),
        "echo count disagrees with echo pointers")
    `TLD_ASSERT(a_pend_from_xfer, pend_reg |-> $past(cmd.xfer),
        "transfer write without a transfer read")
    `TLD_ASSERT(a_edit_tail_xfer_only,
        (edit_tail_reg != $past(edit_tail_reg)) |-> $past(cmd.xfer),
        "edit tail moved outside a transfer")
    `TLD_ASSERT(a_cooked_head_xfer_only,
        (cooked_head_reg != $past(cooked_head_reg)) |-> $past(pend_reg),
        "cooked head moved outside a transfer")
    `TLD_ASSERT_ALWAYS(a_reset_echo_empty, (!rst_n) |-> (echo_count_reg == '0),
        "echo queue not empty in reset")

endmodule

@@ design/tld_ctrl.sv @@
// Controller: sequences accept, execute, ring transfer and result load.
// Depends on tld_pkg for the command and status structs.
module tld_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  tld_pkg::status_t st,
    output tld_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_XFER,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // Drive datapath commands from the current state
    always_comb
    begin
        cmd.load_item = (state_reg == ST_IDLE) && s_valid;
        cmd.exec      = (state_reg == ST_EXEC);
        cmd.xfer      = (state_reg == ST_XFER);
        cmd.load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || m_ready);
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= st.is_enter ? ST_XFER : ST_FINISH;
                end
                ST_XFER:
                begin
                    if (st.xfer_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (cmd.load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

@@ design/tty_line_discipline_buffers.sv @@
// Top level of the terminal line discipline buffers: stream ports, field packing.
// Depends on tld_pkg, tld_ctrl and tld_datapath.
//
// Channel    Direction  Beat contents
// s_axis     in         one command: key event, cooked read or echo drain
// m_axis     out        one result per command
//
// A key, backspace, read, drain or unused command goes from accept through the
// execute and finish states to its result. Enter adds the transfer state, which
// copies the edit characters, newline included, to the cooked ring one character
// per cycle through the edit memory read port. A new command is accepted while a
// result waits on m_axis; a stalled result stops the next one at its load.
// rst_n clears all pointers and counts at once; the memories are not cleared.
module tty_line_discipline_buffers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] key_char, [8] is_special, [11:9] special_kind, [15:12] fkey_index,
    // [16] shift_held, [17] alt_held, [23:18] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [16:9] read_char, [18:17] action,
    // [22:19] console_index, [30:23] cooked_count, [31] zero
    output logic [31:0] m_axis_tdata
);

    tld_pkg::item_t   s_item;
    tld_pkg::cmd_t    cmd;
    tld_pkg::status_t st;
    tld_pkg::result_t result;

    // Unpack the input beat
    always_comb
    begin
        s_item.opcode       = s_axis_tuser;
        s_item.key_char     = s_axis_tdata[7:0];
        s_item.is_special   = s_axis_tdata[8];
        s_item.special_kind = s_axis_tdata[11:9];
        s_item.fkey_index   = s_axis_tdata[15:12];
        s_item.shift_held   = s_axis_tdata[16];
        s_item.alt_held     = s_axis_tdata[17];
    end

    tld_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    tld_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_item (s_item),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

    // Pack the result beat
    assign m_axis_tdata = {1'b0, result.cooked_count, result.console_index,
                           result.action, result.read_char, result.echo_char,
                           result.echo_valid};

endmodule
